/* design/pca_pkg.sv */
// Shared constants, types and helpers of the pose composition accumulator.
// Holds the micro-op sequence and the operand slot map.
// Depends on nothing.
package pca_pkg;

    // Fixed formats
    localparam int FW    = 32;          // width of every field
    localparam int QFB   = 30;          // quaternion fraction bits
    localparam int OPW   = 40;          // operand slot width
    localparam int PRODW = 2 * OPW;     // product width
    localparam int ACCW  = PRODW + 2;   // accumulator width
    localparam int NUMW  = 2 * QFB + 3; // dividend width in normalization
    localparam int SW    = QFB + 3;     // square root width
    localparam int NFLD  = 7;
    localparam int DW    = NFLD * FW;   // tdata width

    // Register indexes
    localparam int CIW = 3;
    localparam logic [CIW-1:0] REG_MOUNT_PX = 3'd0;
    localparam logic [CIW-1:0] REG_MOUNT_QW = 3'd6;

    localparam logic signed [FW-1:0]   QONE32 = FW'(1) << QFB;
    localparam logic signed [ACCW-1:0] QONEW  = ACCW'(1) << QFB;

    // Operand slots
    localparam int SLOTW = 5;
    localparam int NSLOT = 23;
    localparam logic [SLOTW-1:0] SL_X  = 5'd0;
    localparam logic [SLOTW-1:0] SL_Y  = 5'd1;
    localparam logic [SLOTW-1:0] SL_Z  = 5'd2;
    localparam logic [SLOTW-1:0] SL_W  = 5'd3;
    localparam logic [SLOTW-1:0] SL_V0 = 5'd4;
    localparam logic [SLOTW-1:0] SL_V1 = 5'd5;
    localparam logic [SLOTW-1:0] SL_V2 = 5'd6;
    localparam logic [SLOTW-1:0] SL_E0 = 5'd7;
    localparam logic [SLOTW-1:0] SL_E1 = 5'd8;
    localparam logic [SLOTW-1:0] SL_E2 = 5'd9;
    localparam logic [SLOTW-1:0] SL_E3 = 5'd10;
    localparam logic [SLOTW-1:0] SL_A  = 5'd11;
    localparam logic [SLOTW-1:0] SL_D  = 5'd12;
    localparam logic [SLOTW-1:0] SL_C0 = 5'd13;
    localparam logic [SLOTW-1:0] SL_C1 = 5'd14;
    localparam logic [SLOTW-1:0] SL_C2 = 5'd15;
    localparam logic [SLOTW-1:0] SL_R0 = 5'd16;
    localparam logic [SLOTW-1:0] SL_R1 = 5'd17;
    localparam logic [SLOTW-1:0] SL_R2 = 5'd18;
    localparam logic [SLOTW-1:0] SL_N0 = 5'd19;
    localparam logic [SLOTW-1:0] SL_N1 = 5'd20;
    localparam logic [SLOTW-1:0] SL_N2 = 5'd21;
    localparam logic [SLOTW-1:0] SL_N3 = 5'd22;

    // Finish actions after the last product of a sum
    localparam logic [2:0] F_NONE  = 3'd0;
    localparam logic [2:0] F_ST30  = 3'd1; // round by 2^30, store
    localparam logic [2:0] F_ADD29 = 3'd2; // round by 2^29, add to slot
    localparam logic [2:0] F_CL30  = 3'd3; // round by 2^30, clamp, store
    localparam logic [2:0] F_SQ    = 3'd4; // keep raw sum as squared norm

    localparam int PCW = 6;
    localparam logic [PCW-1:0] PC_LAST_ABS = 6'd37;
    localparam logic [PCW-1:0] PC_LAST_REL = 6'd41;

    typedef struct packed {
        logic             clr;
        logic             neg;
        logic [SLOTW-1:0] asel;
        logic [SLOTW-1:0] bsel;
        logic [2:0]       fin;
        logic [SLOTW-1:0] dst;
    } uop_t;

    function automatic uop_t mk(input logic clr, input logic neg,
                                input logic [SLOTW-1:0] a, input logic [SLOTW-1:0] b,
                                input logic [2:0] fin, input logic [SLOTW-1:0] dst);
        uop_t u;
        u.clr  = clr;
        u.neg  = neg;
        u.asel = a;
        u.bsel = b;
        u.fin  = fin;
        u.dst  = dst;
        return u;
    endfunction

    // Sequence: rotation terms, rotated vector, Hamilton product, squared norm
    function automatic uop_t uop_rom(input logic [PCW-1:0] pc);
        uop_t u;
        unique case (pc)
            6'd0:  u = mk(1'b1, 1'b0, SL_W,  SL_W,  F_NONE,  SL_X);
            6'd1:  u = mk(1'b0, 1'b1, SL_X,  SL_X,  F_NONE,  SL_X);
            6'd2:  u = mk(1'b0, 1'b1, SL_Y,  SL_Y,  F_NONE,  SL_X);
            6'd3:  u = mk(1'b0, 1'b1, SL_Z,  SL_Z,  F_ST30,  SL_A);
            6'd4:  u = mk(1'b1, 1'b0, SL_X,  SL_V0, F_NONE,  SL_X);
            6'd5:  u = mk(1'b0, 1'b0, SL_Y,  SL_V1, F_NONE,  SL_X);
            6'd6:  u = mk(1'b0, 1'b0, SL_Z,  SL_V2, F_ST30,  SL_D);
            6'd7:  u = mk(1'b1, 1'b0, SL_Y,  SL_V2, F_NONE,  SL_X);
            6'd8:  u = mk(1'b0, 1'b1, SL_Z,  SL_V1, F_ST30,  SL_C0);
            6'd9:  u = mk(1'b1, 1'b0, SL_Z,  SL_V0, F_NONE,  SL_X);
            6'd10: u = mk(1'b0, 1'b1, SL_X,  SL_V2, F_ST30,  SL_C1);
            6'd11: u = mk(1'b1, 1'b0, SL_X,  SL_V1, F_NONE,  SL_X);
            6'd12: u = mk(1'b0, 1'b1, SL_Y,  SL_V0, F_ST30,  SL_C2);
            6'd13: u = mk(1'b1, 1'b0, SL_A,  SL_V0, F_ST30,  SL_R0);
            6'd14: u = mk(1'b1, 1'b0, SL_D,  SL_X,  F_ADD29, SL_R0);
            6'd15: u = mk(1'b1, 1'b0, SL_W,  SL_C0, F_ADD29, SL_R0);
            6'd16: u = mk(1'b1, 1'b0, SL_A,  SL_V1, F_ST30,  SL_R1);
            6'd17: u = mk(1'b1, 1'b0, SL_D,  SL_Y,  F_ADD29, SL_R1);
            6'd18: u = mk(1'b1, 1'b0, SL_W,  SL_C1, F_ADD29, SL_R1);
            6'd19: u = mk(1'b1, 1'b0, SL_A,  SL_V2, F_ST30,  SL_R2);
            6'd20: u = mk(1'b1, 1'b0, SL_D,  SL_Z,  F_ADD29, SL_R2);
            6'd21: u = mk(1'b1, 1'b0, SL_W,  SL_C2, F_ADD29, SL_R2);
            6'd22: u = mk(1'b1, 1'b0, SL_W,  SL_E0, F_NONE,  SL_X);
            6'd23: u = mk(1'b0, 1'b0, SL_X,  SL_E3, F_NONE,  SL_X);
            6'd24: u = mk(1'b0, 1'b0, SL_Y,  SL_E2, F_NONE,  SL_X);
            6'd25: u = mk(1'b0, 1'b1, SL_Z,  SL_E1, F_CL30,  SL_N0);
            6'd26: u = mk(1'b1, 1'b0, SL_W,  SL_E1, F_NONE,  SL_X);
            6'd27: u = mk(1'b0, 1'b1, SL_X,  SL_E2, F_NONE,  SL_X);
            6'd28: u = mk(1'b0, 1'b0, SL_Y,  SL_E3, F_NONE,  SL_X);
            6'd29: u = mk(1'b0, 1'b0, SL_Z,  SL_E0, F_CL30,  SL_N1);
            6'd30: u = mk(1'b1, 1'b0, SL_W,  SL_E2, F_NONE,  SL_X);
            6'd31: u = mk(1'b0, 1'b0, SL_X,  SL_E1, F_NONE,  SL_X);
            6'd32: u = mk(1'b0, 1'b1, SL_Y,  SL_E0, F_NONE,  SL_X);
            6'd33: u = mk(1'b0, 1'b0, SL_Z,  SL_E3, F_CL30,  SL_N2);
            6'd34: u = mk(1'b1, 1'b0, SL_W,  SL_E3, F_NONE,  SL_X);
            6'd35: u = mk(1'b0, 1'b1, SL_X,  SL_E0, F_NONE,  SL_X);
            6'd36: u = mk(1'b0, 1'b1, SL_Y,  SL_E1, F_NONE,  SL_X);
            6'd37: u = mk(1'b0, 1'b1, SL_Z,  SL_E2, F_CL30,  SL_N3);
            6'd38: u = mk(1'b1, 1'b0, SL_N0, SL_N0, F_NONE,  SL_X);
            6'd39: u = mk(1'b0, 1'b0, SL_N1, SL_N1, F_NONE,  SL_X);
            6'd40: u = mk(1'b0, 1'b0, SL_N2, SL_N2, F_NONE,  SL_X);
            6'd41: u = mk(1'b0, 1'b0, SL_N3, SL_N3, F_SQ,    SL_X);
            default: u = mk(1'b1, 1'b0, SL_X, SL_X, F_NONE,  SL_X);
        endcase
        return u;
    endfunction

    // Quaternion component limited to [-one, one]
    function automatic logic signed [FW-1:0] clamp32(input logic signed [FW-1:0] v);
        logic signed [FW-1:0] r;
        r = v;
        if (v > QONE32)
            r = QONE32;
        else if (v < -QONE32)
            r = -QONE32;
        return r;
    endfunction

endpackage

/* design/pose_compose_accumulator.sv */
// Pose composition accumulator: one item at a time through a micro-op sequencer
// around a bit-serial multiplier, one product per micro-op.
// Absolute pose: 38 products; relative motion: 42 products, then a square root
// and four divisions. A new item is taken only after the result of the last one
// is loaded into the result register, which then frees the sequencer.
// Reset (rst_n, async low): pose identity at origin, mount registers identity.
module pose_compose_accumulator
    import pca_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [DW-1:0]   s_tdata,   // in_px, in_py, in_pz, in_qx, in_qy, in_qz, in_qw
    input  logic            s_tuser,   // req_type
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [DW-1:0]   m_tdata,   // out_px, out_py, out_pz, out_qx, out_qy, out_qz, out_qw
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [CIW-1:0]  cfg_index,
    input  logic [FW-1:0]   cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FETCHA = 3'd1;
    localparam logic [2:0] S_FETCHB = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;
    localparam logic [2:0] S_NSTART = 3'd5;
    localparam logic [2:0] S_NORM   = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    localparam logic signed [ACCW-1:0] HALF30 = ACCW'(1) << (QFB - 1);
    localparam logic signed [ACCW-1:0] HALF29 = ACCW'(1) << (QFB - 2);
    localparam logic signed [OPW:0]    SMAX   = (OPW+1)'(32'sh7FFFFFFF);
    localparam logic signed [OPW:0]    SMIN   = -(OPW+1)'(33'sh080000000);

    logic [2:0]              state_reg;
    logic [PCW-1:0]          pc_reg;
    logic                    typ_reg;
    logic signed [OPW-1:0]   rf_reg [NSLOT];
    logic signed [OPW-1:0]   opa_reg;
    logic signed [ACCW-1:0]  acc_reg;
    logic [63:0]             n2_reg;
    logic [NFLD-1:0][FW-1:0] mount_reg;
    logic [NFLD-1:0][FW-1:0] pose_reg;
    logic [2:0][FW-1:0]      basep_reg;
    logic                    mvalid_reg;
    logic [DW-1:0]           mdata_reg;

    uop_t                    cur;
    logic [SLOTW-1:0]        rd_addr;
    logic signed [OPW-1:0]   rf_rd;
    logic                    accept;
    logic                    mul_done;
    logic signed [PRODW-1:0] mul_prod;
    logic signed [ACCW-1:0]  prod_w;
    logic signed [ACCW-1:0]  r30;
    logic signed [ACCW-1:0]  r29;
    logic signed [OPW-1:0]   r30c;
    logic                    norm_done;
    logic [3:0][FW-1:0]      norm_q;
    logic [3:0][FW-1:0]      ncomp;
    logic [NFLD-1:0][FW-1:0] res;
    logic signed [OPW:0]     psum [3];
    logic                    load_out;

    assign cur      = uop_rom(pc_reg);
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign load_out = (state_reg == S_DONE) && (!mvalid_reg || m_tready);

    // Read port of the operand slots for the sequencer; result assembly reads slots directly
    always_comb
    begin
        unique case (state_reg)
            S_FETCHA: rd_addr = cur.asel;
            S_FETCHB: rd_addr = cur.bsel;
            default:  rd_addr = cur.dst;
        endcase
        rf_rd = rf_reg[rd_addr];
    end

    // Rounding of the accumulated sum
    always_comb
    begin
        prod_w = ACCW'(mul_prod);
        r30    = (acc_reg + HALF30) >>> QFB;
        r29    = (acc_reg + HALF29) >>> (QFB - 1);
        if (r30 > QONEW)
            r30c = OPW'(QONEW);
        else if (r30 < -QONEW)
            r30c = OPW'(-QONEW);
        else
            r30c = r30[OPW-1:0];
    end

    // Result assembly: saturated position, orientation from product or norm
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            psum[i] = (OPW+1)'(signed'(basep_reg[i])) + (OPW+1)'(rf_reg[SL_R0 + i]);
            if (psum[i] > SMAX)
                res[i] = 32'h7FFFFFFF;
            else if (psum[i] < SMIN)
                res[i] = 32'h80000000;
            else
                res[i] = psum[i][FW-1:0];
        end
        for (int i = 0; i < 4; i++)
        begin
            ncomp[i]  = rf_reg[SL_N0 + i][FW-1:0];
            res[3 + i] = typ_reg ? ncomp[i] : norm_q[i];
        end
    end

    pca_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_FETCHB),
        .a     (opa_reg),
        .b     (rf_rd),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    pca_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_NSTART),
        .n2    (n2_reg),
        .comp  (ncomp),
        .done  (norm_done),
        .q     (norm_q)
    );

    // Sequencer, configuration, pose and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pc_reg     <= '0;
            mvalid_reg <= 1'b0;
            mount_reg  <= {QONE32, {(NFLD-1)*FW{1'b0}}};
            pose_reg   <= {QONE32, {(NFLD-1)*FW{1'b0}}};
        end
        else
        begin
            if (cfg_valid && cfg_index <= REG_MOUNT_QW && cfg_index >= REG_MOUNT_PX)
                mount_reg[cfg_index] <= cfg_data;
            if (m_tready && !load_out)
                mvalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        pc_reg    <= '0;
                        state_reg <= S_FETCHA;
                    end
                end
                S_FETCHA: state_reg <= S_FETCHB;
                S_FETCHB: state_reg <= S_MUL;
                S_MUL:
                begin
                    if (mul_done)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (typ_reg && pc_reg == PC_LAST_ABS)
                        state_reg <= S_DONE;
                    else if (pc_reg == PC_LAST_REL)
                        state_reg <= S_NSTART;
                    else
                    begin
                        pc_reg    <= pc_reg + 1'b1;
                        state_reg <= S_FETCHA;
                    end
                end
                S_NSTART: state_reg <= S_NORM;
                S_NORM:
                begin
                    if (norm_done)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (load_out)
                    begin
                        mvalid_reg <= 1'b1;
                        pose_reg   <= res;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Operand slots and accumulator
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            typ_reg <= s_tuser;
            for (int i = 0; i < 4; i++)
                rf_reg[SL_X + i] <= OPW'(clamp32(signed'(s_tuser ? mount_reg[3 + i]
                                                                 : pose_reg[3 + i])));
            for (int i = 0; i < 3; i++)
            begin
                rf_reg[SL_V0 + i] <= OPW'(signed'(s_tdata[i*FW +: FW]));
                basep_reg[i]      <= s_tuser ? mount_reg[i] : pose_reg[i];
            end
            for (int i = 0; i < 4; i++)
                rf_reg[SL_E0 + i] <= OPW'(clamp32(signed'(s_tdata[(3+i)*FW +: FW])));
        end
        if (state_reg == S_FETCHA)
            opa_reg <= rf_rd;
        if (state_reg == S_MUL && mul_done)
            acc_reg <= (cur.clr ? '0 : acc_reg) + (cur.neg ? -prod_w : prod_w);
        if (state_reg == S_FIN)
        begin
            case (cur.fin)
                F_ST30:  rf_reg[cur.dst] <= r30[OPW-1:0];
                F_ADD29: rf_reg[cur.dst] <= rf_rd + r29[OPW-1:0];
                F_CL30:  rf_reg[cur.dst] <= r30c;
                F_SQ:    n2_reg <= acc_reg[63:0];
                default: ;
            endcase
        end
        if (load_out)
            mdata_reg <= res;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

endmodule

/* design/pca_mul.sv */
// Bit-serial signed multiplier: one multiplier bit per cycle.
// Depends on pca_pkg.
module pca_mul
    import pca_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [OPW-1:0]   a,
    input  logic signed [OPW-1:0]   b,
    output logic                    done,
    output logic signed [PRODW-1:0] prod
);

    localparam int CW = $clog2(OPW);
    localparam logic [CW-1:0] LAST = CW'(OPW - 1);

    logic                    busy_reg;
    logic                    done_reg;
    logic [CW-1:0]           cnt_reg;
    logic signed [PRODW-1:0] mc_reg;
    logic [OPW-1:0]          mp_reg;
    logic signed [PRODW-1:0] prod_reg;

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                    busy_reg <= 1'b0;
            end
        end
    end

    // Shift-add datapath; the sign bit carries negative weight
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mc_reg   <= PRODW'(a);
            mp_reg   <= b;
            prod_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (mp_reg[0])
            begin
                if (cnt_reg == LAST)
                    prod_reg <= prod_reg - mc_reg;
                else
                    prod_reg <= prod_reg + mc_reg;
            end
            mc_reg <= mc_reg <<< 1;
            mp_reg <= mp_reg >> 1;
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

/* design/pca_norm.sv */
// Quaternion normalization: bit-serial square root, then one restoring
// division per component, one bit per cycle; a zero norm gives identity. Depends on pca_pkg.
module pca_norm
    import pca_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [63:0]             n2,
    input  logic [3:0][FW-1:0]      comp,
    output logic                    done,
    output logic [3:0][FW-1:0]      q
);

    localparam logic [1:0] N_IDLE = 2'd0;
    localparam logic [1:0] N_SQRT = 2'd1;
    localparam logic [1:0] N_LOAD = 2'd2;
    localparam logic [1:0] N_DIV  = 2'd3;
    localparam int DCW = $clog2(NUMW);
    localparam logic [DCW-1:0] DLAST = DCW'(NUMW - 1);

    logic [1:0]           state_reg;
    logic                 done_reg;
    logic [1:0]           k_reg;
    logic [DCW-1:0]       cnt_reg;
    logic [63:0]          rem_reg;
    logic [63:0]          root_reg;
    logic [63:0]          bit_reg;
    logic [NUMW-1:0]      num_reg;
    logic [SW+1:0]        drem_reg;
    logic [FW-1:0]        quo_reg;
    logic                 neg_reg;
    logic [3:0][FW-1:0]   q_reg;

    logic [63:0]          trial;
    logic [SW:0]          dvs;
    logic [SW+1:0]        drem_sh;
    logic                 qbit;
    logic [SW+1:0]        drem_next;
    logic [FW-1:0]        quo_next;
    logic signed [FW-1:0] ck;
    logic [FW-1:0]        mag;

    // Square root trial and divider step
    always_comb
    begin
        trial     = root_reg + bit_reg;
        dvs       = {root_reg[SW-1:0], 1'b0};
        drem_sh   = {drem_reg[SW:0], num_reg[NUMW-1]};
        qbit      = (drem_sh >= (SW+2)'(dvs));
        drem_next = qbit ? (drem_sh - (SW+2)'(dvs)) : drem_sh;
        quo_next  = {quo_reg[FW-2:0], qbit};
        ck        = signed'(comp[k_reg]);
        mag       = ck[FW-1] ? FW'(-ck) : FW'(ck);
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
            k_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= ((state_reg == N_IDLE) && start && (n2 == 64'd0))
                     || ((state_reg == N_DIV) && (cnt_reg == DLAST) && (k_reg == 2'd3));
            unique case (state_reg)
                N_IDLE:
                begin
                    if (start)
                    begin
                        k_reg <= '0;
                        if (n2 != 64'd0)
                            state_reg <= N_SQRT;
                    end
                end
                N_SQRT:
                begin
                    if (bit_reg[0])
                        state_reg <= N_LOAD;
                end
                N_LOAD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= N_DIV;
                end
                N_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == DLAST)
                    begin
                        k_reg <= k_reg + 1'b1;
                        if (k_reg == 2'd3)
                            state_reg <= N_IDLE;
                        else
                            state_reg <= N_LOAD;
                    end
                end
                default: state_reg <= N_IDLE;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    rem_reg  <= n2;
                    root_reg <= '0;
                    bit_reg  <= 64'd1 << 62;
                    if (n2 == 64'd0)
                        q_reg <= {QONE32, {FW{1'b0}}, {FW{1'b0}}, {FW{1'b0}}};
                end
            end
            N_SQRT:
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg  <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                    root_reg <= root_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            N_LOAD:
            begin
                num_reg  <= (NUMW'(mag) << (QFB + 1)) + NUMW'(root_reg[SW-1:0]);
                drem_reg <= '0;
                quo_reg  <= '0;
                neg_reg  <= ck[FW-1];
            end
            N_DIV:
            begin
                num_reg  <= num_reg << 1;
                drem_reg <= drem_next;
                quo_reg  <= quo_next;
                if (cnt_reg == DLAST)
                    q_reg[k_reg] <= neg_reg ? (-quo_next) : quo_next;
            end
            default: ;
        endcase
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

/* bench/pose_compose_accumulator_tb.sv */
// Self-checking bench for the pose composition accumulator: relative and absolute pose items.
// Holds its own predictor of the pose and mount state.
// Depends on pca_pkg and the pose_compose_accumulator RTL.
`timescale 1ns / 1ps

module pose_compose_accumulator_tb;
    import pca_pkg::*;

    typedef logic signed [127:0] wide_t;

    localparam int            HALF_PERIOD = 6;
    localparam int            IDLE_LIMIT  = 60000;
    localparam int            HOLD_CYCLES = 7000;
    localparam int            N_RANDOM    = 480;
    localparam logic [CIW-1:0] REG_BAD    = 3'd7;   // no register behind it
    localparam logic           REQ_REL    = 1'b0;
    localparam logic           REQ_ABS    = 1'b1;
    localparam wide_t          ONE_Q      = wide_t'(1) <<< QFB;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [DW-1:0]   s_tdata = '0;   // in_px, in_py, in_pz, in_qx, in_qy, in_qz, in_qw
    logic            s_tuser = 1'b0; // req_type
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [DW-1:0]   m_tdata;        // out_px, out_py, out_pz, out_qx, out_qy, out_qz, out_qw
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [CIW-1:0]  cfg_index = '0;
    logic [FW-1:0]   cfg_data = '0;

    // Predictor state: position then quaternion, and the mount registers
    wide_t pose_st [7];
    wide_t mount_st [7];

    logic [DW-1:0] pose_expected [$];
    int            err_count = 0;
    int            idle_cycles = 0;
    int            burst_left = 0;
    bit            hold_rx = 1'b0;

    string fld_name [7] = '{"out_px", "out_py", "out_pz", "out_qx", "out_qy", "out_qz", "out_qw"};

    pose_compose_accumulator u_top (.*);

    always #(HALF_PERIOD) clk = ~clk;

    // ---------------- predictor ----------------
    function automatic wide_t round_sh(input wide_t x, input int s);
        return (x + (wide_t'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic wide_t clamp_q(input wide_t v);
        if (v > ONE_Q) return ONE_Q;
        if (v < -ONE_Q) return -ONE_Q;
        return v;
    endfunction

    function automatic wide_t sat_pos(input wide_t v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Rotate v by quaternion q (x, y, z, w), terms rounded as the block does
    function automatic void rotate_vec(input wide_t q [4], input wide_t v [3],
                                       output wide_t r [3]);
        wide_t a, d;
        wide_t c [3];
        a = round_sh(q[3]*q[3] - q[0]*q[0] - q[1]*q[1] - q[2]*q[2], QFB);
        d = round_sh(q[0]*v[0] + q[1]*v[1] + q[2]*v[2], QFB);
        c[0] = round_sh(q[1]*v[2] - q[2]*v[1], QFB);
        c[1] = round_sh(q[2]*v[0] - q[0]*v[2], QFB);
        c[2] = round_sh(q[0]*v[1] - q[1]*v[0], QFB);
        for (int i = 0; i < 3; i++)
            r[i] = round_sh(a * v[i], QFB) + round_sh(d * q[i], QFB - 1)
                 + round_sh(q[3] * c[i], QFB - 1);
    endfunction

    function automatic void hamilton(input wide_t p [4], input wide_t q [4],
                                     output wide_t r [4]);
        r[0] = clamp_q(round_sh(p[3]*q[0] + p[0]*q[3] + p[1]*q[2] - p[2]*q[1], QFB));
        r[1] = clamp_q(round_sh(p[3]*q[1] - p[0]*q[2] + p[1]*q[3] + p[2]*q[0], QFB));
        r[2] = clamp_q(round_sh(p[3]*q[2] + p[0]*q[1] - p[1]*q[0] + p[2]*q[3], QFB));
        r[3] = clamp_q(round_sh(p[3]*q[3] - p[0]*q[0] - p[1]*q[1] - p[2]*q[2], QFB));
    endfunction

    // Zero quaternion normalizes to identity; rounding ties away from zero
    function automatic void normalize(inout wide_t q [4]);
        wide_t n2, s, m, v;
        n2 = 0;
        for (int i = 0; i < 4; i++) n2 += q[i] * q[i];
        if (n2 == 0)
        begin
            q = '{0, 0, 0, ONE_Q};
            return;
        end
        s = wide_t'(floor_sqrt(n2[63:0]));
        for (int i = 0; i < 4; i++)
        begin
            m = (q[i] < 0) ? -q[i] : q[i];
            v = (m * ONE_Q * 2 + s) / (2 * s);
            q[i] = (q[i] < 0) ? -v : v;
        end
    endfunction

    // Next pose for one item; updates the predictor state
    function automatic logic [DW-1:0] next_pose(input logic req, input logic [DW-1:0] d);
        wide_t vp [3];
        wide_t vq [4];
        wide_t base [4];
        wide_t rot [3];
        wide_t nq [4];
        logic [DW-1:0] res;
        for (int i = 0; i < 3; i++) vp[i] = wide_t'(signed'(d[i*FW +: FW]));
        for (int i = 0; i < 4; i++) vq[i] = clamp_q(wide_t'(signed'(d[(i+3)*FW +: FW])));
        for (int i = 0; i < 4; i++)
            base[i] = clamp_q(req == REQ_REL ? pose_st[3+i] : mount_st[3+i]);
        rotate_vec(base, vp, rot);
        hamilton(base, vq, nq);
        if (req == REQ_REL)
        begin
            normalize(nq);
            for (int i = 0; i < 3; i++) pose_st[i] = sat_pos(pose_st[i] + rot[i]);
        end
        else
            for (int i = 0; i < 3; i++) pose_st[i] = sat_pos(mount_st[i] + rot[i]);
        for (int i = 0; i < 4; i++) pose_st[3+i] = nq[i];
        for (int i = 0; i < 7; i++) res[i*FW +: FW] = pose_st[i][FW-1:0];
        return res;
    endfunction

    // ---------------- drivers ----------------
    // Sends one item; the sender runs in bursts with random gaps
    task automatic send_item(input logic req, input logic [FW-1:0] f [7]);
        logic [DW-1:0] d;
        int            gap;
        for (int i = 0; i < 7; i++) d[i*FW +: FW] = f[i];
        s_tdata <= d;
        s_tuser <= req;
        if (!s_tvalid) s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        pose_expected.push_back(next_pose(req, d));
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300) : 0;
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(0, 8);
        end
    endtask

    // Stop offering items and wait until every expected pose has arrived
    task automatic drain;
        if (s_tvalid) s_tvalid <= 1'b0;
        while (pose_expected.size() != 0) @(negedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CIW-1:0] idx, input logic [FW-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        if (idx < REG_BAD) mount_st[idx] = wide_t'(signed'(val));
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [FW-1:0] rand_pos();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        endcase
    endfunction

    function automatic logic [FW-1:0] rand_quat();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
            default: return $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
        endcase
    endfunction

    // ---------------- receiver and checker ----------------
    always @(negedge clk)
    begin
        case (($time / (HALF_PERIOD * 2 * 3000)) % 3)
            0: m_tready <= !hold_rx;
            1: m_tready <= !hold_rx && ($urandom_range(0, 1) == 1);
            default: m_tready <= !hold_rx && ($urandom_range(0, 9) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        logic [DW-1:0] exp_v;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pose_expected.size() == 0)
            begin
                $error("unexpected pose result %h", m_tdata);
                err_count++;
            end
            else
            begin
                exp_v = pose_expected.pop_front();
                for (int i = 0; i < 7; i++)
                    if (m_tdata[i*FW +: FW] !== exp_v[i*FW +: FW])
                    begin
                        $error("%s expected %0d actual %0d", fld_name[i],
                               $signed(exp_v[i*FW +: FW]), $signed(m_tdata[i*FW +: FW]));
                        err_count++;
                    end
            end
        end
    end

    // Watchdog: cycles without any accepted item on any channel
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------- tests ----------------
    task automatic test_relative_edges;
        logic [FW-1:0] f [7];
        f = '{0, 0, 0, 0, 0, 0, QONE32};
        send_item(REQ_REL, f);
        // position saturates high, then low
        f = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, QONE32};
        send_item(REQ_REL, f);
        send_item(REQ_REL, f);
        f = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, QONE32};
        send_item(REQ_REL, f);
        send_item(REQ_REL, f);
        // components beyond one are clamped
        f = '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
              32'h7fff_ffff, 32'h8000_0000, 32'h4000_0001, 32'hbfff_ffff};
        send_item(REQ_REL, f);
        // zero product gives identity
        f = '{32'h0001_0000, 0, 0, 0, 0, 0, 0};
        send_item(REQ_REL, f);
        // non-unit rotation
        f = '{32'h0010_0000, 32'hfff0_0000, 32'h0008_0000,
              32'h1000_0000, 32'h2000_0000, 32'h0800_0000, 32'h2000_0000};
        send_item(REQ_REL, f);
        send_item(REQ_REL, f);
        f = '{32'hffff_ffff, 32'h0000_0001, 32'h5555_5555,
              32'hc000_0000, 32'h4000_0000, 32'hc000_0000, 32'h4000_0000};
        send_item(REQ_REL, f);
        drain();
    endtask

    task automatic test_absolute_edges;
        logic [FW-1:0] f [7];
        f = '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0, 0, QONE32};
        send_item(REQ_ABS, f);
        f = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001};
        send_item(REQ_ABS, f);
        f = '{32'haaaa_aaaa, 32'h5555_5555, 0, 0, 0, 0, 0};
        send_item(REQ_ABS, f);
        f = '{32'h0004_0000, 32'h0000_8000, 32'hfffc_0000, 0, 0, 0, QONE32};
        send_item(REQ_REL, f);
        drain();
    endtask

    // Writes every register with the given mount, then runs a few items
    task automatic test_mount(input logic [FW-1:0] m [7], input int n_items);
        logic [FW-1:0] f [7];
        for (int i = 0; i < 7; i++) write_reg(REG_MOUNT_PX + CIW'(i), m[i]);
        write_reg(REG_BAD, $urandom);
        for (int k = 0; k < n_items; k++)
        begin
            for (int i = 0; i < 3; i++) f[i] = rand_pos();
            for (int i = 3; i < 7; i++) f[i] = rand_quat();
            send_item(k % 2 == 0 ? REQ_ABS : REQ_REL, f);
        end
        drain();
    endtask

    // Random phase: runs of relative motion with occasional absolute resets, receiver optionally held at first
    task automatic test_random(input int n_items, input bit with_hold);
        logic [FW-1:0] f [7];
        if (with_hold)
            fork
                begin
                    hold_rx = 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    hold_rx = 1'b0;
                end
            join_none
        for (int k = 0; k < n_items; k++)
        begin
            for (int i = 0; i < 3; i++) f[i] = rand_pos();
            for (int i = 3; i < 7; i++) f[i] = rand_quat();
            send_item($urandom_range(0, 5) == 0 ? REQ_ABS : REQ_REL, f);
        end
        drain();
    endtask

    initial
    begin
        logic [FW-1:0] m [7];
        for (int i = 0; i < 7; i++)
        begin
            pose_st[i]  = (i == 6) ? ONE_Q : 0;
            mount_st[i] = (i == 6) ? ONE_Q : 0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_relative_edges();
        test_absolute_edges();
        m = '{32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000,
              32'h4000_0000, 32'hc000_0000, 32'h0000_0000, 32'h4000_0000};
        test_mount(m, 4);
        m = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000,
              32'h7fff_ffff, 32'h8000_0000, 32'h4000_0001, 32'h8000_0000};
        test_mount(m, 4);
        m = '{32'h0012_3456, 32'hffed_cba9, 32'h0000_8000,
              32'h16a0_9e66, 32'h0000_0000, 32'h0000_0000, 32'h2d41_3ccd};
        test_mount(m, 2);
        test_random(N_RANDOM / 2, 1'b1);
        m = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
              32'h0000_0000, 32'h0000_0000, 32'h0000_0000, QONE32};
        test_mount(m, 2);
        test_random(N_RANDOM / 2, 1'b0);

        repeat (2500) @(posedge clk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
design/pca_pkg.sv
design/pca_mul.sv
design/pca_norm.sv
design/pose_compose_accumulator.sv
bench/pose_compose_accumulator_tb.sv
